// File: rtl/core/i2cms_pkg.sv
// Shared types and codes for the I2C master register sequencer.
// No dependencies; imported by the sequencer core, output buffer and top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // command selector (s_tuser)
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_EVENT = 2'd3;

  // bus core event codes
  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_TX_MODE    = 3'd1;
  localparam logic [2:0] EV_RX_MODE    = 3'd2;
  localparam logic [2:0] EV_BYTE_SENT  = 3'd3;
  localparam logic [2:0] EV_BYTE_RECV  = 3'd4;

  // acknowledge control
  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_ON   = 2'd1;
  localparam logic [1:0] ACK_OFF  = 2'd2;

  localparam int unsigned OUT_BITS = 48;

  typedef struct packed {
    logic       rejected;
    logic       busy_res;
    logic [7:0] rx_position;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [1:0] ack_ctrl;
    logic       gen_stop;
    logic       gen_start;
    logic [7:0] data_out;
    logic       send_data;
    logic [7:0] address_byte;
    logic       send_address;
  } res_t;

  // struct is declared MSB first, so the last field lands in bit 0
  function automatic logic [OUT_BITS-1:0] pack_res(input res_t r);
    return OUT_BITS'(r);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/i2cms_store.sv
// Write data store: synchronous RAM, one write and one registered read port.
// Write-first forwarding when both ports hit the same entry. No package use.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/i2cms_ctrl.sv
// Sequencer core: command decode, bus event handling and transfer state.
// Uses i2cms_pkg and instantiates i2cms_store.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_ctrl #(
  parameter int unsigned TX_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        acc,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  dev_addr,
  input  wire logic [7:0]  reg_addr,
  input  wire logic [7:0]  length,
  input  wire logic [7:0]  tx_data,
  input  wire logic [2:0]  event_code,
  input  wire logic [7:0]  rx_data,
  output i2cms_pkg::res_t  res
);
  import i2cms_pkg::*;

  localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TX_DEPTH + 1);

  logic          busy, busy_next;
  logic          read_mode, read_mode_next;
  logic [7:0]    device, device_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] tx_pos, tx_pos_next;
  logic [CW-1:0] tx_total, tx_total_next;
  logic [7:0]    rx_done, rx_done_next;
  logic [7:0]    rx_total, rx_total_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          have_tx;
  logic          len_bad_wr;

  // rdata always holds store[tx_pos]: the read address follows tx_pos_next
  i2cms_store #(.DEPTH(TX_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (tx_pos_next[AW-1:0]),
    .rdata (rdata)
  );

  assign have_tx    = (tx_pos < tx_total);
  assign len_bad_wr = ({1'b0, length} > 9'(TX_DEPTH - 1));

  always_comb begin
    busy_next      = busy;
    read_mode_next = read_mode;
    device_next    = device;
    fill_next      = fill;
    tx_pos_next    = tx_pos;
    tx_total_next  = tx_total;
    rx_done_next   = rx_done;
    rx_total_next  = rx_total;
    we             = 1'b0;
    waddr          = '0;
    wdata          = reg_addr;
    res            = '0;
    if (acc) begin
      case (cmd)
        CMD_PUSH: begin
          if (busy || (fill == CW'(TX_DEPTH))) begin
            res.rejected = 1'b1;
          end else begin
            we        = 1'b1;
            waddr     = fill[AW-1:0];
            wdata     = tx_data;
            fill_next = fill + 1'b1;
          end
        end
        CMD_WRITE: begin
          if (busy || len_bad_wr) begin
            res.rejected = 1'b1;
          end else begin
            busy_next      = 1'b1;
            read_mode_next = 1'b0;
            device_next    = dev_addr;
            we             = 1'b1;
            tx_pos_next    = '0;
            tx_total_next  = CW'({1'b0, length} + 9'd1);
            fill_next      = CW'(1);
            res.gen_start  = 1'b1;
          end
        end
        CMD_READ: begin
          if (busy || (length == 8'd0)) begin
            res.rejected = 1'b1;
          end else begin
            busy_next      = 1'b1;
            read_mode_next = 1'b1;
            device_next    = dev_addr;
            we             = 1'b1;
            tx_pos_next    = '0;
            tx_total_next  = CW'(1);
            rx_done_next   = 8'd0;
            rx_total_next  = length;
            res.ack_ctrl   = ACK_ON;
            res.gen_start  = 1'b1;
          end
        end
        CMD_EVENT: begin
          if (busy) begin
            case (event_code)
              EV_START_SENT: begin
                // direction bit is read only after the register byte went out
                res.send_address = 1'b1;
                res.address_byte = {device[7:1], read_mode && (tx_pos != '0)};
              end
              EV_TX_MODE: begin
                if (have_tx) begin
                  res.send_data = 1'b1;
                  res.data_out  = rdata;
                  tx_pos_next   = tx_pos + 1'b1;
                end
              end
              EV_RX_MODE: begin
                if (read_mode && (rx_total == 8'd1)) begin
                  res.ack_ctrl = ACK_OFF;
                  res.gen_stop = 1'b1;
                end
              end
              EV_BYTE_SENT: begin
                if (read_mode) begin
                  res.gen_start = 1'b1;
                end else if (have_tx) begin
                  res.send_data = 1'b1;
                  res.data_out  = rdata;
                  tx_pos_next   = tx_pos + 1'b1;
                end else begin
                  res.gen_stop = 1'b1;
                  busy_next    = 1'b0;
                end
              end
              EV_BYTE_RECV: begin
                if (read_mode) begin
                  res.rx_valid    = 1'b1;
                  res.rx_byte     = rx_data;
                  res.rx_position = rx_done;
                  rx_done_next    = rx_done + 8'd1;
                  // NACK and stop ahead of the final byte
                  if (({1'b0, rx_done_next} + 9'd1) == {1'b0, rx_total}) begin
                    res.ack_ctrl = ACK_OFF;
                    res.gen_stop = 1'b1;
                  end
                  if (rx_done_next == rx_total) begin
                    busy_next = 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      res.busy_res = busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      read_mode <= 1'b0;
      device    <= 8'd0;
      fill      <= CW'(1);
      tx_pos    <= '0;
      tx_total  <= '0;
      rx_done   <= 8'd0;
      rx_total  <= 8'd0;
    end else begin
      busy      <= busy_next;
      read_mode <= read_mode_next;
      device    <= device_next;
      fill      <= fill_next;
      tx_pos    <= tx_pos_next;
      tx_total  <= tx_total_next;
      rx_done   <= rx_done_next;
      rx_total  <= rx_total_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/i2cms_obuf.sv
// Output register with one skid entry between the sequencer and the result port.
// Uses i2cms_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_obuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire i2cms_pkg::res_t in_res,
  output logic                 in_ready,
  output logic                 out_valid,
  output i2cms_pkg::res_t      out_res,
  input  wire logic            out_ready
);
  import i2cms_pkg::*;

  logic skid_valid;
  res_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_valid) begin
        out_res <= in_res;
      end
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_register_sequencer.sv
// A result is registered in the output buffer before it appears on m_tvalid.
// Throughput: one command per cycle while s_tready is high; the write store read for
// the next data byte is issued from the updated byte pointer, so events never wait.
// s_tready drops only while the one-entry skid holds a result the sink refused.
// Reset (rst, synchronous, active high) clears busy, counters (fill restarts at 1)
// and both buffers; the write store contents are undefined until pushed.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_sequencer #(
  parameter int unsigned TX_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // commands: tuser = cmd[1:0]
  // tdata = dev_addr[7:0], reg_addr[15:8], length[23:16], tx_data[31:24],
  //         event_code[34:32], rx_data[42:35], zero[47:43]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  // results: tdata = send_address[0], address_byte[8:1], send_data[9],
  //   data_out[17:10], gen_start[18], gen_stop[19], ack_ctrl[21:20],
  //   rx_valid[22], rx_byte[30:23], rx_position[38:31], busy_res[39],
  //   rejected[40], zero[47:41]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata
);
  import i2cms_pkg::*;

  logic acc;
  res_t res;
  res_t out_res;

  // a transaction on the command side is processed in the cycle it is taken
  assign acc = s_tvalid && s_tready;

  i2cms_ctrl #(.TX_DEPTH(TX_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .cmd        (s_tuser),
    .dev_addr   (s_tdata[7:0]),
    .reg_addr   (s_tdata[15:8]),
    .length     (s_tdata[23:16]),
    .tx_data    (s_tdata[31:24]),
    .event_code (s_tdata[34:32]),
    .rx_data    (s_tdata[42:35]),
    .res        (res)
  );

  // result register plus skid entry absorbs one result while the sink stalls
  i2cms_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = pack_res(out_res);

endmodule

`default_nettype wire

// File: rtl/core/i2cms_checker.sv
// Port-level checks for the I2C master register sequencer, bound to the top level.
// Sees only the top-level ports; no package use.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  // refused command carries no bus action
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[40]) |->
      (!m_tdata[0] && !m_tdata[9] && !m_tdata[18] && !m_tdata[19] && !m_tdata[22]))
    else $error("rejected result carries a bus action");

  // address and data byte are never requested together
  a_addr_data_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
    else $error("address and data send in one result");

  // acknowledge is dropped only together with a stop request
  a_nack_with_stop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[21]) |-> m_tdata[19])
    else $error("acknowledge disabled without stop");

  // skid is empty on the first cycle out of reset
  a_ready_after_rst: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> s_tready)
    else $error("command side not ready after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn while stalled");

endmodule

bind i2c_master_register_sequencer i2cms_checker u_i2cms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
